FILE: rtl/mdm_pkg.sv
// Shared constants, types and state encodings of the mixer, decimator and magnitude block.
package mdm_pkg;

  // Oscillator table depth and the largest decimation it supports.
  localparam int MAX_DECIM = 64;
  localparam int IDX_W     = $clog2(MAX_DECIM);

  // Field widths of samples, oscillator parts, accumulators and the result.
  localparam int SMP_W   = 8;
  localparam int LO_W    = 15;
  localparam int PROD_W  = SMP_W + LO_W;
  localparam int ACC_W   = 30;
  localparam int ROOT_W  = ACC_W - 1;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int ITER_W  = $clog2(ROOT_W);
  localparam int DECIM_W = 7;
  localparam int MAG_W   = 22;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  localparam logic [DECIM_W-1:0] DECIM_RESET = DECIM_W'(8);
  localparam logic [DECIM_W-1:0] DECIM_MAX   = DECIM_W'(MAX_DECIM);
  localparam logic [MAG_W-1:0]   MAG_MAX     = '1;

  // Kinds of input transaction, carried in tuser.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TABLE  = 1'b1;

  // One oscillator table entry.
  typedef struct packed {
    logic signed [LO_W-1:0] im;
    logic signed [LO_W-1:0] re;
  } lo_entry_t;

  // Controls from the sequencer to the multiply-accumulate datapath.
  typedef struct packed {
    logic capture;
    logic prod_en;
    logic acc_en;
    logic clear;
  } mac_ctl_t;

  // Controls from the sequencer to the magnitude unit.
  typedef struct packed {
    logic start;
    logic ack;
  } mag_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_MAG
  } ctl_state_t;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_SQUARE,
    MS_SUM,
    MS_ROOT,
    MS_DIV,
    MS_DONE
  } mag_state_t;

endpackage

FILE: rtl/mdm_osc_ram.sv
// Oscillator table memory: one write port and one registered read port.
module mdm_osc_ram (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [mdm_pkg::IDX_W-1:0]   wr_addr,
  input  mdm_pkg::lo_entry_t          wr_data,
  input  logic                        rd_en,
  input  logic [mdm_pkg::IDX_W-1:0]   rd_addr,
  output mdm_pkg::lo_entry_t          rd_data
);

  mdm_pkg::lo_entry_t mem [mdm_pkg::MAX_DECIM];

  // Synchronous write and read; read data is registered and appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/mdm_mac.sv
// Complex multiply of a sample by an oscillator entry and the complex accumulator.
module mdm_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mdm_pkg::mac_ctl_t                   ctl,
  input  logic signed [mdm_pkg::SMP_W-1:0]    sample_i,
  input  logic signed [mdm_pkg::SMP_W-1:0]    sample_q,
  input  mdm_pkg::lo_entry_t                  lo,
  output logic signed [mdm_pkg::ACC_W-1:0]    acc_re,
  output logic signed [mdm_pkg::ACC_W-1:0]    acc_im
);

  logic signed [mdm_pkg::SMP_W-1:0]  si_r;
  logic signed [mdm_pkg::SMP_W-1:0]  sq_r;
  logic signed [mdm_pkg::PROD_W-1:0] p_ir_r;
  logic signed [mdm_pkg::PROD_W-1:0] p_qi_r;
  logic signed [mdm_pkg::PROD_W-1:0] p_ii_r;
  logic signed [mdm_pkg::PROD_W-1:0] p_qr_r;
  logic signed [mdm_pkg::ACC_W-1:0]  acc_re_r;
  logic signed [mdm_pkg::ACC_W-1:0]  acc_im_r;
  logic signed [mdm_pkg::ACC_W-1:0]  acc_re_nxt;
  logic signed [mdm_pkg::ACC_W-1:0]  acc_im_nxt;

  // Sample hold and the four partial products, each registered.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      si_r <= sample_i;
      sq_r <= sample_q;
    end
    if (ctl.prod_en) begin
      p_ir_r <= si_r * $signed(lo.re);
      p_qi_r <= sq_r * $signed(lo.im);
      p_ii_r <= si_r * $signed(lo.im);
      p_qr_r <= sq_r * $signed(lo.re);
    end
  end

  // Accumulate; a clear wins over a pending sum.
  always_comb begin
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    if (ctl.clear) begin
      acc_re_nxt = '0;
      acc_im_nxt = '0;
    end else if (ctl.acc_en) begin
      acc_re_nxt = acc_re_r + mdm_pkg::ACC_W'(p_ir_r) - mdm_pkg::ACC_W'(p_qi_r);
      acc_im_nxt = acc_im_r + mdm_pkg::ACC_W'(p_ii_r) + mdm_pkg::ACC_W'(p_qr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else begin
      acc_re_r <= acc_re_nxt;
      acc_im_r <= acc_im_nxt;
    end
  end

  assign acc_re = acc_re_r;
  assign acc_im = acc_im_r;

endmodule

FILE: rtl/mdm_mag.sv
// Magnitude unit: squares, bit-serial square root, bit-serial division by decim, saturation.
module mdm_mag (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mdm_pkg::mag_ctl_t                   ctl,
  input  logic [mdm_pkg::DECIM_W-1:0]         decim,
  input  logic signed [mdm_pkg::ACC_W-1:0]    acc_re,
  input  logic signed [mdm_pkg::ACC_W-1:0]    acc_im,
  output logic                                done,
  output logic [mdm_pkg::MAG_W-1:0]           result
);

  mdm_pkg::mag_state_t state_r;
  mdm_pkg::mag_state_t state_nxt;

  logic [mdm_pkg::ROOT_W-1:0]    abs_re;
  logic [mdm_pkg::ROOT_W-1:0]    abs_im;
  logic [mdm_pkg::RAD_W-1:0]     sq_re_r;
  logic [mdm_pkg::RAD_W-1:0]     sq_im_r;
  logic [mdm_pkg::RAD_W-1:0]     sq_re_nxt;
  logic [mdm_pkg::RAD_W-1:0]     sq_im_nxt;
  logic [mdm_pkg::RAD_W-1:0]     rad_r;
  logic [mdm_pkg::RAD_W-1:0]     rad_nxt;
  logic [mdm_pkg::ROOT_W-1:0]    root_r;
  logic [mdm_pkg::ROOT_W-1:0]    root_nxt;
  logic [mdm_pkg::REM_W-1:0]     rem_r;
  logic [mdm_pkg::REM_W-1:0]     rem_nxt;
  logic [mdm_pkg::REM_W+1:0]     rem_sh;
  logic [mdm_pkg::REM_W+1:0]     trial;
  logic [mdm_pkg::ROOT_W-1:0]    quot_r;
  logic [mdm_pkg::ROOT_W-1:0]    quot_nxt;
  logic [mdm_pkg::DECIM_W-1:0]   drem_r;
  logic [mdm_pkg::DECIM_W-1:0]   drem_nxt;
  logic [mdm_pkg::DECIM_W:0]     dsh;
  logic [mdm_pkg::DECIM_W-1:0]   d_r;
  logic [mdm_pkg::DECIM_W-1:0]   d_nxt;
  logic [mdm_pkg::ITER_W-1:0]    iter_r;
  logic [mdm_pkg::ITER_W-1:0]    iter_nxt;
  logic                          last_iter;

  // Magnitudes of the accumulators; the sums never reach the sign bit's weight.
  assign abs_re = acc_re[mdm_pkg::ACC_W-1] ? mdm_pkg::ROOT_W'(-acc_re)
                                           : mdm_pkg::ROOT_W'(acc_re);
  assign abs_im = acc_im[mdm_pkg::ACC_W-1] ? mdm_pkg::ROOT_W'(-acc_im)
                                           : mdm_pkg::ROOT_W'(acc_im);

  assign last_iter = (iter_r == mdm_pkg::ITER_W'(mdm_pkg::ROOT_W - 1));

  // One root digit per step: bring down two radicand bits and try root*4+1.
  assign rem_sh = {rem_r, rad_r[mdm_pkg::RAD_W-1 -: 2]};
  assign trial  = (mdm_pkg::REM_W + 2)'({root_r, 2'b01});

  // One quotient bit per step of the restoring division.
  assign dsh = {drem_r, quot_r[mdm_pkg::ROOT_W-1]};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mdm_pkg::MS_IDLE:   if (ctl.start) state_nxt = mdm_pkg::MS_SQUARE;
      mdm_pkg::MS_SQUARE: state_nxt = mdm_pkg::MS_SUM;
      mdm_pkg::MS_SUM:    state_nxt = mdm_pkg::MS_ROOT;
      mdm_pkg::MS_ROOT:   if (last_iter) state_nxt = mdm_pkg::MS_DIV;
      mdm_pkg::MS_DIV:    if (last_iter) state_nxt = mdm_pkg::MS_DONE;
      mdm_pkg::MS_DONE:   if (ctl.ack) state_nxt = mdm_pkg::MS_IDLE;
      default:            state_nxt = mdm_pkg::MS_IDLE;
    endcase
  end

  // Datapath updates for each state.
  always_comb begin
    sq_re_nxt = sq_re_r;
    sq_im_nxt = sq_im_r;
    rad_nxt   = rad_r;
    root_nxt  = root_r;
    rem_nxt   = rem_r;
    quot_nxt  = quot_r;
    drem_nxt  = drem_r;
    d_nxt     = d_r;
    iter_nxt  = iter_r;
    case (state_r)
      mdm_pkg::MS_IDLE: begin
        if (ctl.start) begin
          d_nxt = decim;
        end
      end
      mdm_pkg::MS_SQUARE: begin
        sq_re_nxt = abs_re * abs_re;
        sq_im_nxt = abs_im * abs_im;
      end
      mdm_pkg::MS_SUM: begin
        rad_nxt  = sq_re_r + sq_im_r;
        root_nxt = '0;
        rem_nxt  = '0;
        iter_nxt = '0;
      end
      mdm_pkg::MS_ROOT: begin
        rad_nxt = rad_r << 2;
        if (rem_sh >= trial) begin
          rem_nxt  = mdm_pkg::REM_W'(rem_sh - trial);
          root_nxt = {root_r[mdm_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = mdm_pkg::REM_W'(rem_sh);
          root_nxt = {root_r[mdm_pkg::ROOT_W-2:0], 1'b0};
        end
        iter_nxt = iter_r + mdm_pkg::ITER_W'(1);
        if (last_iter) begin
          quot_nxt = root_nxt;
          drem_nxt = '0;
          iter_nxt = '0;
        end
      end
      mdm_pkg::MS_DIV: begin
        if (dsh >= {1'b0, d_r}) begin
          drem_nxt = mdm_pkg::DECIM_W'(dsh - {1'b0, d_r});
          quot_nxt = {quot_r[mdm_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          drem_nxt = mdm_pkg::DECIM_W'(dsh);
          quot_nxt = {quot_r[mdm_pkg::ROOT_W-2:0], 1'b0};
        end
        iter_nxt = iter_r + mdm_pkg::ITER_W'(1);
      end
      mdm_pkg::MS_DONE: begin
        iter_nxt = '0;
      end
      default: begin
        iter_nxt = '0;
      end
    endcase
  end

  // Outputs: the done flag, and the quotient saturated to the result width.
  always_comb begin
    done   = (state_r == mdm_pkg::MS_DONE);
    result = (quot_r > mdm_pkg::ROOT_W'(mdm_pkg::MAG_MAX)) ? mdm_pkg::MAG_MAX
                                                           : quot_r[mdm_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mdm_pkg::MS_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sq_re_r <= sq_re_nxt;
    sq_im_r <= sq_im_nxt;
    rad_r   <= rad_nxt;
    root_r  <= root_nxt;
    rem_r   <= rem_nxt;
    quot_r  <= quot_nxt;
    drem_r  <= drem_nxt;
    d_r     <= d_nxt;
  end

endmodule

FILE: rtl/mix_decimate_magnitude.sv
// Top level: sequencer, oscillator table, multiply-accumulate and magnitude unit.
//
// Input stream (in_*): each transaction is either an I/Q sample (tuser = 0) or an
// oscillator table write (tuser = 1). A sample is multiplied by the table entry for
// its place in the current group and added to a complex accumulator; tlast marks
// the last sample of a buffer, after which a partial group is dropped.
// Output stream (out_*): one magnitude per group of decim samples, equal to
// floor(sqrt(re^2 + im^2) / decim) and saturated to 22 bits.
// Configuration (cfg_*): a write sets decim; 0 acts as 1, above 64 acts as 64.
// Write it only while the block is idle.
//
// Steps: a table write is taken while the block is idle and leaves it idle. A sample
// passes through table read, products and accumulate. The sample that closes a group
// goes on to square, sum, the square-root unit (29 steps), the divider (29 steps) and
// the hand-over. The result is loaded into the output register once the last one is taken.
//
// Reset (rst_n low, synchronous) clears the accumulators, the group position and
// the output valid, and sets decim to 8. The table is not cleared: each entry must
// be written before a sample uses it. A finished result waits in the output
// register; while it is stalled, further samples are still taken up to the next
// group end, where the block holds until the previous result has been taken.
module mix_decimate_magnitude (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // sample_i [7:0], sample_q [15:8], table_index [21:16], lo_real [36:22],
  // lo_imag [51:37], zero [55:52]
  input  logic [mdm_pkg::IN_TDATA_W-1:0]      in_tdata,
  // op [0]
  input  logic                                in_tuser,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // magnitude [21:0], zero [23:22]
  output logic [mdm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mdm_pkg::DECIM_W-1:0]         cfg_data
);

  // Field positions in in_tdata.
  localparam int SI_LSB  = 0;
  localparam int SQ_LSB  = SI_LSB + mdm_pkg::SMP_W;
  localparam int IDX_LSB = SQ_LSB + mdm_pkg::SMP_W;
  localparam int LR_LSB  = IDX_LSB + mdm_pkg::IDX_W;
  localparam int LI_LSB  = LR_LSB + mdm_pkg::LO_W;

  mdm_pkg::ctl_state_t state_r;
  mdm_pkg::ctl_state_t state_nxt;

  logic [mdm_pkg::DECIM_W-1:0] decim_r;
  logic [mdm_pkg::DECIM_W-1:0] decim_nxt;
  logic [mdm_pkg::DECIM_W-1:0] decim_eff;
  logic [mdm_pkg::DECIM_W-1:0] count_r;
  logic [mdm_pkg::DECIM_W-1:0] count_nxt;
  logic [mdm_pkg::DECIM_W-1:0] count_inc;
  logic [mdm_pkg::IDX_W-1:0]   pos;
  logic                        group_end;
  logic                        last_r;
  logic                        last_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [mdm_pkg::MAG_W-1:0]   out_mag_r;
  logic [mdm_pkg::MAG_W-1:0]   out_mag_nxt;

  logic                        accept;
  logic                        is_sample;
  logic                        tab_wr;
  logic                        tab_rd;
  logic                        load_out;
  mdm_pkg::lo_entry_t          tab_wdata;
  mdm_pkg::lo_entry_t          tab_rdata;
  mdm_pkg::mac_ctl_t           mac_ctl;
  mdm_pkg::mag_ctl_t           mag_ctl;
  logic signed [mdm_pkg::ACC_W-1:0] acc_re;
  logic signed [mdm_pkg::ACC_W-1:0] acc_im;
  logic                        mag_done;
  logic [mdm_pkg::MAG_W-1:0]   mag_result;

  // Effective decimation and group bookkeeping.
  always_comb begin
    if (decim_r == '0) begin
      decim_eff = mdm_pkg::DECIM_W'(1);
    end else if (decim_r > mdm_pkg::DECIM_MAX) begin
      decim_eff = mdm_pkg::DECIM_MAX;
    end else begin
      decim_eff = decim_r;
    end
    count_inc = count_r + mdm_pkg::DECIM_W'(1);
    group_end = (count_inc >= decim_eff);
    pos = (count_r >= mdm_pkg::DECIM_MAX) ? mdm_pkg::IDX_W'(mdm_pkg::MAX_DECIM - 1)
                                          : count_r[mdm_pkg::IDX_W-1:0];
  end

  assign accept    = in_tvalid & in_tready;
  assign is_sample = (in_tuser == mdm_pkg::OP_SAMPLE);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mdm_pkg::ST_IDLE: if (accept && is_sample) state_nxt = mdm_pkg::ST_READ;
      mdm_pkg::ST_READ: state_nxt = mdm_pkg::ST_ACC;
      mdm_pkg::ST_ACC:  state_nxt = group_end ? mdm_pkg::ST_MAG : mdm_pkg::ST_IDLE;
      mdm_pkg::ST_MAG:  if (load_out) state_nxt = mdm_pkg::ST_IDLE;
      default:          state_nxt = mdm_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready       = (state_r == mdm_pkg::ST_IDLE);
    tab_wr          = 1'b0;
    tab_rd          = 1'b0;
    load_out        = 1'b0;
    mac_ctl         = '0;
    mag_ctl         = '0;
    case (state_r)
      mdm_pkg::ST_IDLE: begin
        tab_wr          = accept & ~is_sample;
        tab_rd          = accept & is_sample;
        mac_ctl.capture = accept & is_sample;
      end
      mdm_pkg::ST_READ: begin
        mac_ctl.prod_en = 1'b1;
      end
      mdm_pkg::ST_ACC: begin
        mac_ctl.acc_en = 1'b1;
        mac_ctl.clear  = ~group_end & last_r;
        mag_ctl.start  = group_end;
      end
      mdm_pkg::ST_MAG: begin
        load_out      = mag_done & (~out_valid_r | out_tready);
        mag_ctl.ack   = load_out;
        mac_ctl.clear = load_out;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  // Group position, buffer-end flag, configuration and output register.
  always_comb begin
    count_nxt     = count_r;
    last_nxt      = last_r;
    decim_nxt     = decim_r;
    out_valid_nxt = out_valid_r;
    out_mag_nxt   = out_mag_r;
    if (mac_ctl.capture) begin
      last_nxt = in_tlast;
    end
    if (state_r == mdm_pkg::ST_ACC) begin
      count_nxt = (group_end || last_r) ? '0 : count_inc;
    end
    if (cfg_valid && cfg_ready) begin
      decim_nxt = cfg_data;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_mag_nxt   = mag_result;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mdm_pkg::ST_IDLE;
      count_r     <= '0;
      decim_r     <= mdm_pkg::DECIM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      decim_r     <= decim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r    <= last_nxt;
    out_mag_r <= out_mag_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = mdm_pkg::OUT_TDATA_W'(out_mag_r);

  assign tab_wdata.re = in_tdata[LR_LSB +: mdm_pkg::LO_W];
  assign tab_wdata.im = in_tdata[LI_LSB +: mdm_pkg::LO_W];

  mdm_osc_ram u_osc_ram (
    .clk     (clk),
    .wr_en   (tab_wr),
    .wr_addr (in_tdata[IDX_LSB +: mdm_pkg::IDX_W]),
    .wr_data (tab_wdata),
    .rd_en   (tab_rd),
    .rd_addr (pos),
    .rd_data (tab_rdata)
  );

  mdm_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .sample_i ($signed(in_tdata[SI_LSB +: mdm_pkg::SMP_W])),
    .sample_q ($signed(in_tdata[SQ_LSB +: mdm_pkg::SMP_W])),
    .lo       (tab_rdata),
    .acc_re   (acc_re),
    .acc_im   (acc_im)
  );

  mdm_mag u_mag (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mag_ctl),
    .decim  (decim_eff),
    .acc_re (acc_re),
    .acc_im (acc_im),
    .done   (mag_done),
    .result (mag_result)
  );

endmodule

FILE: rtl/mdm_checker.sv
// Port-level checks of the mixer, decimator and magnitude block, bound to the top level.
module mdm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [mdm_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  // A result that is stalled holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or vanished");

  // A table write leaves the block ready again in the next cycle.
  a_table_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == mdm_pkg::OP_TABLE) |=> in_tready)
    else $error("block not ready after a table write");

  // A sample occupies the block while the table entry is read.
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == mdm_pkg::OP_SAMPLE) |=> !in_tready)
    else $error("sample accepted without a table read cycle");

  // A new result is loaded only as the block returns to accepting input.
  a_result_release: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result appeared while the block was still busy");

endmodule

bind mix_decimate_magnitude mdm_checker u_mdm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the mixer, decimator and magnitude block.
module tb_top;
  import mdm_pkg::*;

  // Cycles allowed after the last result for the block to finish any work in progress.
  localparam int DRAIN_CYCLES = 80;
  // Length of the long receiver hold-off that fills the block up.
  localparam int HOLD_CYCLES  = 300;

  // One input transaction, unpacked into its fields.
  typedef struct {
    logic                    op;
    logic signed [SMP_W-1:0] si;
    logic signed [SMP_W-1:0] sq;
    logic                    last;
    logic [IDX_W-1:0]        idx;
    logic signed [LO_W-1:0]  lr;
    logic signed [LO_W-1:0]  li;
  } stream_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [DECIM_W-1:0]     cfg_data;

  // Predicted state of the block: oscillator table, accumulators, group position, decim.
  int                 lo_re [MAX_DECIM];
  int                 lo_im [MAX_DECIM];
  longint             acc_re;
  longint             acc_im;
  int unsigned        group_pos;
  logic [DECIM_W-1:0] decim_reg;

  // Magnitudes still owed by the block, oldest first.
  logic [MAG_W-1:0] mag_expected_q [$];

  int mismatches  = 0;
  bit idle_on     = 1'b1;
  int rx_hold_len = 0;

  mix_decimate_magnitude dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock with a period of 12 time units.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Integer square root, rounded down, found one result bit at a time from the top.
  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int k = 31; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // Decimation factor as the block applies it: zero acts as one, the top is clamped.
  function automatic int unsigned decim_in_use();
    if (decim_reg == 0) return 1;
    if (decim_reg > MAX_DECIM) return MAX_DECIM;
    return decim_reg;
  endfunction

  // Updates the predicted state for one accepted transaction and queues any magnitude.
  task automatic predict_item(input stream_item_t it);
    int unsigned     d;
    int unsigned     pos;
    longint unsigned mag_r;
    longint unsigned mag_i;
    longint unsigned mag;
    d = decim_in_use();
    if (it.op == OP_TABLE) begin
      lo_re[it.idx] = it.lr;
      lo_im[it.idx] = it.li;
    end else begin
      pos = (group_pos >= MAX_DECIM) ? MAX_DECIM - 1 : group_pos;
      acc_re += int'(it.si) * lo_re[pos] - int'(it.sq) * lo_im[pos];
      acc_im += int'(it.si) * lo_im[pos] + int'(it.sq) * lo_re[pos];
      group_pos++;
      if (group_pos >= d) begin
        mag_r = (acc_re < 0) ? -acc_re : acc_re;
        mag_i = (acc_im < 0) ? -acc_im : acc_im;
        mag   = floor_sqrt(mag_r * mag_r + mag_i * mag_i) / d;
        if (mag > MAG_MAX) mag = MAG_MAX;
        mag_expected_q.push_back(mag[MAG_W-1:0]);
        acc_re    = 0;
        acc_im    = 0;
        group_pos = 0;
      end else if (it.last) begin
        // The end of a buffer drops the partial sum.
        acc_re    = 0;
        acc_im    = 0;
        group_pos = 0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [MAG_W-1:0] got,
                                 input logic [MAG_W-1:0] want);
    $display("ERROR at %0t: %s, got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Every result transaction is checked against the oldest expected magnitude.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (mag_expected_q.size() == 0) begin
        report_mismatch("result with none expected", out_tdata[MAG_W-1:0], '0);
      end else begin
        if (out_tdata[MAG_W-1:0] !== mag_expected_q[0])
          report_mismatch("magnitude", out_tdata[MAG_W-1:0], mag_expected_q[0]);
        void'(mag_expected_q.pop_front());
      end
    end
  end

  // Receiver readiness: random stalls, plus the long hold-off when one is requested.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_len != 0) begin
        out_tready = 1'b0;
        repeat (rx_hold_len) @(negedge clk);
        rx_hold_len = 0;
        out_tready  = 1'b1;
      end else if (rst_n && idle_on && $urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Sends one input transaction; called and returns at a falling edge, valid left high.
  task automatic send_item(input stream_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tuser        = it.op;
    in_tlast        = it.last;
    in_tdata        = '0;
    in_tdata[51:0]  = {it.li, it.lr, it.idx, it.sq, it.si};
    in_tvalid       = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_item(it);
    @(negedge clk);
  endtask

  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return -128;
      1:       return 127;
      2:       return 0;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [LO_W-1:0] pick_lo();
    case ($urandom_range(0, 9))
      0:       return -16384;
      1:       return 16383;
      2:       return 0;
      default: return LO_W'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic signed [SMP_W-1:0] si,
                             input logic signed [SMP_W-1:0] sq, input logic last);
    stream_item_t it;
    it.op   = OP_SAMPLE;
    it.si   = si;
    it.sq   = sq;
    it.last = last;
    it.idx  = IDX_W'($urandom);
    it.lr   = LO_W'($urandom);
    it.li   = LO_W'($urandom);
    send_item(it);
  endtask

  // The sample fields and tlast ride along at random, as the block ignores them here.
  task automatic send_table(input logic [IDX_W-1:0] idx, input logic signed [LO_W-1:0] lr,
                            input logic signed [LO_W-1:0] li);
    stream_item_t it;
    it.op   = OP_TABLE;
    it.si   = SMP_W'($urandom);
    it.sq   = SMP_W'($urandom);
    it.last = 1'($urandom);
    it.idx  = idx;
    it.lr   = lr;
    it.li   = li;
    send_item(it);
  endtask

  // Mostly samples; buffer ends are rarer for long groups so that most groups complete.
  task automatic send_random_item();
    stream_item_t it;
    it.op   = ($urandom_range(0, 99) < 8) ? OP_TABLE : OP_SAMPLE;
    it.si   = pick_sample();
    it.sq   = pick_sample();
    it.last = ($urandom_range(0, 3 * decim_in_use()) == 0);
    it.idx  = IDX_W'($urandom);
    it.lr   = pick_lo();
    it.li   = pick_lo();
    send_item(it);
  endtask

  // Waits until every expected result has arrived and the block has gone quiet.
  task automatic settle();
    in_tvalid = 1'b0;
    while (mag_expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_decim(input logic [DECIM_W-1:0] value);
    settle();
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    decim_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Every table entry is written once before any sample can read it.
  task automatic test_table_load();
    for (int k = 0; k < MAX_DECIM; k++) send_table(IDX_W'(k), pick_lo(), pick_lo());
  endtask

  // Field extremes with one sample per group, including the saturating corner.
  task automatic test_extremes();
    write_decim(1);
    send_table(0, -16384, -16384);
    send_sample(-128, -128, 1'b0);
    send_table(0, 16383, 16383);
    send_sample(127, 127, 1'b0);
    send_sample(-128, 127, 1'b1);
    send_table(0, 16383, -16384);
    send_sample(127, -128, 1'b0);
    send_sample(0, 0, 1'b0);
    // A decimation of zero behaves as one.
    write_decim(0);
    send_sample(-1, -1, 1'b0);
    send_sample(-128, -128, 1'b0);
  endtask

  // Partial sums dropped at a buffer end, a buffer end on a group end, and a table
  // write in the middle of a group.
  task automatic test_buffer_end();
    write_decim(4);
    send_sample(pick_sample(), pick_sample(), 1'b0);
    send_sample(pick_sample(), pick_sample(), 1'b0);
    send_sample(pick_sample(), pick_sample(), 1'b1);
    repeat (3) send_sample(pick_sample(), pick_sample(), 1'b0);
    send_sample(pick_sample(), pick_sample(), 1'b1);
    send_sample(pick_sample(), pick_sample(), 1'b0);
    send_sample(pick_sample(), pick_sample(), 1'b0);
    send_table(2, pick_lo(), pick_lo());
    send_sample(pick_sample(), pick_sample(), 1'b0);
    send_sample(pick_sample(), pick_sample(), 1'b0);
  endtask

  // Lowering decim below the current group position makes the next sample close the group.
  task automatic test_decim_lowered();
    write_decim(12);
    repeat (7) send_sample(pick_sample(), pick_sample(), 1'b0);
    write_decim(3);
    send_sample(pick_sample(), pick_sample(), 1'b0);
  endtask

  // The receiver holds off for a long stretch while samples keep coming.
  task automatic test_backpressure();
    write_decim(2);
    rx_hold_len = HOLD_CYCLES;
    repeat (24) send_sample(pick_sample(), pick_sample(), 1'b0);
  endtask

  // Random transactions over several decimation settings; the last phase runs without idling.
  task automatic test_random();
    int phase_decim [10];
    int phase_len   [10];
    phase_decim = '{2, 1, 64, 127, 0, 5, -1, -1, -1, 3};
    phase_len   = '{150, 90, 200, 140, 60, 150, 120, 120, 120, 200};
    for (int p = 0; p < 10; p++) begin
      if (phase_decim[p] < 0)
        write_decim(DECIM_W'($urandom_range(1, 24)));
      else
        write_decim(DECIM_W'(phase_decim[p]));
      if (p == 9) idle_on = 1'b0;
      repeat (phase_len[p]) send_random_item();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_SAMPLE;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    acc_re    = 0;
    acc_im    = 0;
    group_pos = 0;
    decim_reg = DECIM_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_table_load();
    test_extremes();
    test_buffer_end();
    test_decim_lowered();
    test_backpressure();
    test_random();

    settle();
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog for a block that hangs or loses results.
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: mix_decimate_magnitude.f
rtl/mdm_pkg.sv
rtl/mdm_osc_ram.sv
rtl/mdm_mac.sv
rtl/mdm_mag.sv
rtl/mix_decimate_magnitude.sv
rtl/mdm_checker.sv
tb/sv/tb_top.sv
